FILE: rtl/rms_pkg.sv
// Shared types and constants of the running mean and standard deviation block.
package rms_pkg;

  localparam int unsigned SUM_BITS   = 32;
  localparam int unsigned SQ_BITS    = 48;
  localparam int unsigned FIELD_BITS = 16;
  localparam int unsigned DIV_STEPS  = 48;
  localparam int unsigned ROOT_STEPS = 32;
  localparam int unsigned STEP_BITS  = 6;
  localparam logic [FIELD_BITS-1:0] GOAL_RESET = 16'd10;
  // 5.0 in Q8.8.
  localparam logic signed [SUM_BITS:0] FIVE_Q8_8 = 33'sd1280;

  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_SAMPLE  = 2'd1,
    CMD_PREEMPT = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_MUL,
    ST_DIFF,
    ST_ROOT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic start;
    logic take;
    logic div_load;
    logic div_step;
    logic mul;
    logic diff;
    logic root_step;
    logic out_load;
  } ctrl_t;

  typedef struct packed {
    logic last;
  } stat_t;

endpackage

FILE: rtl/rms_if.sv
// Valid/ready channel interfaces for samples in and results out.
interface rms_in_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    cmd;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, input ready, output cmd, output sample);
  modport sink   (input valid, output ready, input cmd, input sample);
endinterface

interface rms_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        sample_index;
  logic signed [15:0] echo_sample;
  logic signed [15:0] mean;
  logic [15:0]        std_dev;
  logic               last;
  logic               aborted;

  modport source (output valid, input ready, output sample_index, output echo_sample,
                  output mean, output std_dev, output last, output aborted);
  modport sink   (input valid, output ready, input sample_index, input echo_sample,
                  input mean, input std_dev, input last, input aborted);
endinterface

FILE: rtl/rms_ctrl.sv
// Sequencer of the block: command decoding, active flag, step counting, result valid.
module rms_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [1:0]     in_cmd_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  rms_pkg::stat_t stat_i,
  output rms_pkg::ctrl_t ctrl_o
);
  import rms_pkg::*;

  state_e               state_q, state_d;
  logic                 active_q, active_d;
  logic                 vld_q, vld_d;
  logic [STEP_BITS-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      active_q <= 1'b0;
      vld_q    <= 1'b0;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      active_q <= active_d;
      vld_q    <= vld_d;
      cnt_q    <= cnt_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    active_d = active_q;
    cnt_d    = cnt_q;
    ctrl_o   = '0;
    vld_d    = vld_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_cmd_i)
            CMD_START: begin
              ctrl_o.start = 1'b1;
              active_d     = 1'b1;
            end
            CMD_SAMPLE: begin
              if (active_q) begin
                ctrl_o.take = 1'b1;
                state_d     = ST_LOAD;
                if (stat_i.last) begin
                  active_d = 1'b0;
                end
              end
            end
            CMD_PREEMPT: active_d = 1'b0;
            default: ;
          endcase
        end
      end
      ST_LOAD: begin
        ctrl_o.div_load = 1'b1;
        cnt_d           = '0;
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        ctrl_o.div_step = 1'b1;
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == STEP_BITS'(DIV_STEPS - 1)) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        ctrl_o.mul = 1'b1;
        state_d    = ST_DIFF;
      end
      ST_DIFF: begin
        ctrl_o.diff = 1'b1;
        cnt_d       = '0;
        state_d     = ST_ROOT;
      end
      ST_ROOT: begin
        ctrl_o.root_step = 1'b1;
        cnt_d            = cnt_q + 1'b1;
        if (cnt_q == STEP_BITS'(ROOT_STEPS - 1)) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        // The result register is free or is being emptied by this transfer.
        if (!vld_q || out_ready_i) begin
          ctrl_o.out_load = 1'b1;
          vld_d           = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = vld_q;

endmodule

FILE: rtl/rms_dpath.sv
// Accumulators, shared serial dividers, squarer, serial square root and result register.
module rms_dpath #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [15:0]                   cfg_data_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  rms_pkg::ctrl_t                ctrl_i,
  output rms_pkg::stat_t                stat_o,
  output logic [15:0]                   sample_index_o,
  output logic signed [15:0]            echo_sample_o,
  output logic signed [15:0]            mean_o,
  output logic [15:0]                   std_dev_o,
  output logic                          last_o,
  output logic                          aborted_o
);
  import rms_pkg::*;

  localparam int unsigned SQR_BITS = 2 * SAMPLE_BITS;

  logic [FIELD_BITS-1:0]         goal_q;
  logic [COUNT_BITS-1:0]         count_q, count_d;
  logic signed [SUM_BITS-1:0]    sum_q, sum_d;
  logic [SQ_BITS-1:0]            sq_q, sq_d;
  logic signed [SAMPLE_BITS-1:0] smp_q;
  logic                          last_q;

  // Accumulator update for the incoming sample.
  logic [SAMPLE_BITS-1:0] smp_abs;
  logic [SQR_BITS-1:0]    smp_sqr;
  logic signed [SUM_BITS:0] sum_wide;
  logic [63:0]            sq_wide;

  always_comb begin
    smp_abs  = sample_i[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample_i) : SAMPLE_BITS'(sample_i);
    smp_sqr  = SQR_BITS'(smp_abs) * SQR_BITS'(smp_abs);
    count_d  = (&count_q) ? count_q : count_q + 1'b1;
    sum_wide = (SUM_BITS + 1)'(sum_q) + (SUM_BITS + 1)'(sample_i);
    if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
      sum_d = sum_wide[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}} : {1'b0, {(SUM_BITS-1){1'b1}}};
    end else begin
      sum_d = sum_wide[SUM_BITS-1:0];
    end
    sq_wide = 64'(sq_q) + 64'(smp_sqr);
    sq_d    = (sq_wide[63:SQ_BITS] != '0) ? '1 : sq_wide[SQ_BITS-1:0];
    stat_o.last = 32'(count_d) >= 32'(goal_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_q  <= GOAL_RESET;
      count_q <= '0;
      sum_q   <= '0;
      sq_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        goal_q <= cfg_data_i;
      end
      if (ctrl_i.start) begin
        count_q <= '0;
        sum_q   <= '0;
        sq_q    <= '0;
      end else if (ctrl_i.take) begin
        count_q <= count_d;
        sum_q   <= sum_d;
        sq_q    <= sq_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.take) begin
      smp_q  <= sample_i;
      last_q <= stat_o.last;
    end
  end

  // Two restoring dividers stepped together: |sum| / count and sumsq / count.
  // Each dividend register takes in quotient bits as it shifts out dividend bits.
  logic                  neg_q;
  logic [SQ_BITS-1:0]    dva_q, dvb_q;
  logic [COUNT_BITS-1:0] rema_q, remb_q;
  logic [COUNT_BITS:0]   tra, trb;
  logic                  qa, qb;

  always_comb begin
    tra = {rema_q, dva_q[SQ_BITS-1]};
    trb = {remb_q, dvb_q[SQ_BITS-1]};
    qa  = tra >= {1'b0, count_q};
    qb  = trb >= {1'b0, count_q};
  end

  // Square root of the variance term, one root bit a step.
  logic [31:0] mabs_q;
  logic [63:0] msq_q;
  logic [63:0] v_q;
  logic [31:0] root_q;
  logic [34:0] rrem_q;
  logic [34:0] rtr, rtrial;
  logic        rq;

  always_comb begin
    rtr    = {rrem_q[32:0], v_q[63:62]};
    rtrial = {1'b0, root_q, 2'b01};
    rq     = rtr >= rtrial;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.div_load) begin
      neg_q  <= sum_q[SUM_BITS-1];
      // The magnitude of the most negative sum only fits as an unsigned value.
      dva_q  <= SQ_BITS'($unsigned(sum_q[SUM_BITS-1] ? SUM_BITS'(-sum_q) : SUM_BITS'(sum_q)));
      dvb_q  <= sq_q;
      rema_q <= '0;
      remb_q <= '0;
    end else if (ctrl_i.div_step) begin
      dva_q  <= {dva_q[SQ_BITS-2:0], qa};
      dvb_q  <= {dvb_q[SQ_BITS-2:0], qb};
      rema_q <= qa ? COUNT_BITS'(tra - {1'b0, count_q}) : tra[COUNT_BITS-1:0];
      remb_q <= qb ? COUNT_BITS'(trb - {1'b0, count_q}) : trb[COUNT_BITS-1:0];
    end
    if (ctrl_i.mul) begin
      mabs_q <= dva_q[31:0];
      msq_q  <= 64'(dva_q[31:0]) * 64'(dva_q[31:0]);
    end
    if (ctrl_i.diff) begin
      v_q    <= (64'(dvb_q) >= msq_q) ? 64'(dvb_q) - msq_q : msq_q - 64'(dvb_q);
      root_q <= '0;
      rrem_q <= '0;
    end else if (ctrl_i.root_step) begin
      v_q    <= {v_q[61:0], 2'b00};
      root_q <= {root_q[30:0], rq};
      rrem_q <= rq ? rtr - rtrial : rtr;
    end
  end

  // Result register.
  logic signed [SUM_BITS:0] mean_full;
  logic signed [15:0]       mean_sat;
  logic [15:0]              sd_sat;

  always_comb begin
    mean_full = neg_q ? -$signed({1'b0, mabs_q}) : $signed({1'b0, mabs_q});
    if (mean_full > 33'sd32767) begin
      mean_sat = 16'sh7FFF;
    end else if (mean_full < -33'sd32768) begin
      mean_sat = -16'sh8000;
    end else begin
      mean_sat = mean_full[15:0];
    end
    sd_sat = (root_q[31:16] != '0) ? 16'hFFFF : root_q[15:0];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      sample_index_o <= 16'(count_q);
      echo_sample_o  <= 16'(smp_q);
      mean_o         <= mean_sat;
      std_dev_o      <= sd_sat;
      last_o         <= last_q;
      aborted_o      <= last_q && (mean_full < FIVE_Q8_8);
    end
  end

endmodule

FILE: rtl/running_mean_stddev.sv
// Top level of the running mean and standard deviation block.
//
//   channel   direction  handshake      payload
//   in_i      sink       valid/ready    cmd, sample
//   out_o     source     valid/ready    sample_index, echo_sample, mean, std_dev, last, aborted
//   cfg       write      cfg_we_i       cfg_data_i (goal_samples)
//
// Start, preempt and ignored samples are handled in the idle state. A sample taken while
// active goes through one load, 48 steps of the two serial dividers, one squaring, one
// subtract and 32 steps of the serial square root before its result load.
// The result waits in an output register, so a stalled result only holds back the
// next sample at its own result load. Reset clears the accumulators and makes the
// block inactive with a goal of 10.
module running_mean_stddev #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  rms_in_if.sink       in_i,
  rms_out_if.source    out_o,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_data_i
);
  import rms_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  rms_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_cmd_i    (in_i.cmd),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  rms_dpath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .sample_i       (in_i.sample),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .sample_index_o (out_o.sample_index),
    .echo_sample_o  (out_o.echo_sample),
    .mean_o         (out_o.mean),
    .std_dev_o      (out_o.std_dev),
    .last_o         (out_o.last),
    .aborted_o      (out_o.aborted)
  );

endmodule
